[design/stepper_accel_profile_unit_defines.svh]
// Assertion helpers shared by the stepper ramp RTL
`ifndef STEPPER_ACCEL_PROFILE_UNIT_DEFINES_SVH
`define STEPPER_ACCEL_PROFILE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SAPU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SAPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sapu_pkg.sv]
`default_nettype none
package sapu_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MIN_INTERVAL   = 2'd1;
    localparam logic [1:0] CFG_STOP_NUMERATOR = 2'd2;

    localparam int CFG_W      = 60;
    localparam int INTERVAL_W = 32;
    localparam int STOP_W     = 31;
    localparam int PERIOD_W   = 24;

    localparam logic [INTERVAL_W-1:0] FIRST_INTERVAL_RST = 32'd244738048;
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST   = 32'd256000000;
    localparam logic [CFG_W-1:0]      STOP_NUMERATOR_RST = 60'd32768000000000000;

    localparam logic [STOP_W-1:0]     STOP_MAX     = 31'h7FFF_FFFF;
    localparam logic [31:0]           RAMP_MAX     = 32'h7FFF_FFFF;
    localparam logic [PERIOD_W-1:0]   PERIOD_MAX   = 24'hFF_FFFF;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 32'hFFFF_FFFF;

    // serial arithmetic unit
    localparam int OPA_W     = 60;
    localparam int OPB_W     = 64;
    localparam int RES_W     = 64;
    localparam int MUL_W     = 32;
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 60;
    localparam int COUNT_W   = 6;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [OPA_W-1:0] opa;
        logic [OPB_W-1:0] opb;
    } t_ser_cmd;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] result;
    } t_ser_rsp;

endpackage
`default_nettype wire

[design/sapu_serial.sv]
`default_nettype none
`include "stepper_accel_profile_unit_defines.svh"
module sapu_serial (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sapu_pkg::t_ser_cmd i_cmd,
    output sapu_pkg::t_ser_rsp      o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    sapu_pkg::t_op                  r_op;
    logic [sapu_pkg::COUNT_W-1:0]   r_count;
    logic [sapu_pkg::MUL_W-1:0]     r_mcand;
    logic [sapu_pkg::MUL_W-1:0]     r_hi;
    logic [sapu_pkg::MUL_W-1:0]     r_lo;
    logic [sapu_pkg::OPA_W-1:0]     r_quo;
    logic [sapu_pkg::OPB_W-1:0]     r_rem;
    logic [sapu_pkg::OPB_W-1:0]     r_dvs;

    logic [sapu_pkg::MUL_W:0]       n_sum;
    logic [sapu_pkg::OPB_W:0]       n_shift;
    logic [sapu_pkg::OPB_W+1:0]     n_diff;

    // one multiplier bit per cycle: add and shift right
    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    // one quotient bit per cycle: shift in, trial subtract
    assign n_shift = {r_rem, r_quo[sapu_pkg::OPA_W-1]};
    assign n_diff  = {1'b0, n_shift} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                case (i_cmd.op)
                    sapu_pkg::OP_MUL: begin
                        r_mcand <= i_cmd.opa[sapu_pkg::MUL_W-1:0];
                        r_hi    <= '0;
                        r_lo    <= i_cmd.opb[sapu_pkg::MUL_W-1:0];
                        r_count <= sapu_pkg::COUNT_W'(sapu_pkg::MUL_STEPS - 1);
                    end
                    default: begin
                        r_quo   <= i_cmd.opa;
                        r_rem   <= '0;
                        r_dvs   <= i_cmd.opb;
                        r_count <= sapu_pkg::COUNT_W'(sapu_pkg::DIV_STEPS - 1);
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    sapu_pkg::OP_MUL: begin
                        r_hi <= n_sum[sapu_pkg::MUL_W:1];
                        r_lo <= {n_sum[0], r_lo[sapu_pkg::MUL_W-1:1]};
                    end
                    default: begin
                        if (!n_diff[sapu_pkg::OPB_W+1]) begin
                            r_rem <= n_diff[sapu_pkg::OPB_W-1:0];
                            r_quo <= {r_quo[sapu_pkg::OPA_W-2:0], 1'b1};
                        end else begin
                            r_rem <= n_shift[sapu_pkg::OPB_W-1:0];
                            r_quo <= {r_quo[sapu_pkg::OPA_W-2:0], 1'b0};
                        end
                    end
                endcase
                // finish on the last bit
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == sapu_pkg::OP_MUL) ? {r_hi, r_lo}
                        : {{(sapu_pkg::RES_W - sapu_pkg::OPA_W){1'b0}}, r_quo};

    `SAPU_ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n, i_cmd.start, !r_busy, "start while busy")
    `SAPU_ASSERT_IMPL(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy), "stray done")
    `SAPU_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done && !r_busy, "done too long")

endmodule
`default_nettype wire

[design/stepper_accel_profile_unit.sv]
// Stepper pulse generator with a trapezoidal speed ramp.
// Input channel (i_in_valid / o_in_ready) carries one word per item: i_kind 0 is a
// one-microsecond tick, i_kind 1 loads i_target_position as the new target.
// Output channel (o_out_valid / i_out_ready) returns exactly one word per item with
// the step flag, coil pattern, position, direction, busy flag and step interval.
// The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) loads first_interval,
// min_interval and stop_numerator; write only while no item is in flight.
// A tick that does not step or an unchanged target skips the ramp update and goes to the
// output hand-over. A step or a new target runs the ramp update on one shared
// bit-serial unit: a square of the interval (skipped when stopped), a divide for
// steps-to-stop and a divide for the interval term. One item is worked on at a
// time; the next is taken as soon as the previous word sits in the output register.
// Reset (synchronous, active low) clears position, target and ramp state and loads
// the register defaults; no word is pending after reset.
// A stalled receiver holds the output word; one more item may be taken meanwhile
// and its word waits until the register frees.
`default_nettype none
`include "stepper_accel_profile_unit_defines.svh"
module stepper_accel_profile_unit #(
    parameter int POSITION_BITS = 32,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [59:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_kind,
    input  wire logic signed [31:0] i_target_position,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_stepped,
    output logic [3:0]              o_coil_pattern,
    output logic signed [31:0]      o_position,
    output logic                    o_moving_clockwise,
    output logic                    o_busy_res,
    output logic [23:0]             o_interval_us
);

    localparam int PB     = POSITION_BITS;
    localparam int DIST_W = ((POSITION_BITS > 31) ? POSITION_BITS : 31) + 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST,
        S_MUL,
        S_DIVS,
        S_DECIDE,
        S_PREP,
        S_DIVD,
        S_FIN,
        S_OUT
    } t_state;

    // configuration
    logic [sapu_pkg::INTERVAL_W-1:0] r_first_interval;
    logic [sapu_pkg::INTERVAL_W-1:0] r_min_interval;
    logic [sapu_pkg::CFG_W-1:0]      r_stop_numerator;

    // motion state
    t_state                          r_state;
    logic [PB-1:0]                   r_position;
    logic [PB-1:0]                   r_goal;
    logic signed [31:0]              r_ramp;
    logic [sapu_pkg::INTERVAL_W-1:0] r_interval;
    logic [sapu_pkg::PERIOD_W-1:0]   r_step_period;
    logic                            r_dir;
    logic                            r_in_motion;
    logic [31:0]                     r_ticks;
    logic signed [DIST_W-1:0]        r_dist;
    logic [sapu_pkg::STOP_W-1:0]     r_stop;
    logic                            r_stepped;
    sapu_pkg::t_ser_cmd              r_cmd;
    sapu_pkg::t_ser_rsp              w_rsp;

    // output word
    logic                            r_out_valid;
    logic                            r_out_stepped;
    logic [3:0]                      r_out_coil;
    logic [31:0]                     r_out_position;
    logic                            r_out_dir;
    logic                            r_out_busy;
    logic [sapu_pkg::PERIOD_W-1:0]   r_out_interval;

    logic [PB+31:0]                  n_target_ext;
    logic [PB-1:0]                   n_target;
    logic [31:0]                     n_ticks;
    logic signed [DIST_W-1:0]        n_dist;
    logic signed [DIST_W-1:0]        n_stop_s;
    logic signed [DIST_W-1:0]        n_dsum;
    logic                            n_dist_zero;
    logic                            n_dist_pos;
    logic                            n_far;
    logic                            n_cw_side;
    logic signed [31:0]              n_neg_stop;
    logic signed [31:0]              n_neg_ramp;
    logic signed [31:0]              n_ramp_dec;
    logic signed [33:0]              n_den;
    logic [33:0]                     n_mag;
    logic [33:0]                     n_csum;
    logic [sapu_pkg::INTERVAL_W-1:0] n_csat;
    logic [sapu_pkg::INTERVAL_W-1:0] n_cnew;
    logic [sapu_pkg::INTERVAL_W-1:0] n_ipart;
    logic [sapu_pkg::PERIOD_W-1:0]   n_period;
    logic [sapu_pkg::OPA_W-1:0]      n_quot;
    logic [PB+31:0]                  n_pos_ext;

    sapu_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .o_rsp   (w_rsp)
    );

    // load configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_interval <= sapu_pkg::FIRST_INTERVAL_RST;
            r_min_interval   <= sapu_pkg::MIN_INTERVAL_RST;
            r_stop_numerator <= sapu_pkg::STOP_NUMERATOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sapu_pkg::CFG_FIRST_INTERVAL:
                    r_first_interval <= i_cfg_data[sapu_pkg::INTERVAL_W-1:0];
                sapu_pkg::CFG_MIN_INTERVAL:
                    r_min_interval <= i_cfg_data[sapu_pkg::INTERVAL_W-1:0];
                sapu_pkg::CFG_STOP_NUMERATOR:
                    r_stop_numerator <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // target folded into the position width
    assign n_target_ext = {{PB{i_target_position[31]}}, i_target_position};
    assign n_target     = n_target_ext[PB-1:0];

    // saturating elapsed-tick count
    assign n_ticks = (r_ticks == 32'hFFFF_FFFF) ? r_ticks : r_ticks + 32'd1;

    // exact signed distance to the target
    assign n_dist = $signed({{(DIST_W-PB){r_goal[PB-1]}}, r_goal})
                  - $signed({{(DIST_W-PB){r_position[PB-1]}}, r_position});

    // pick accelerate or decelerate from steps-to-stop
    assign n_dist_zero = (r_dist == '0);
    assign n_dist_pos  = !r_dist[DIST_W-1] && !n_dist_zero;
    assign n_stop_s    = $signed({{(DIST_W-sapu_pkg::STOP_W){1'b0}}, r_stop});
    assign n_dsum      = r_dist + n_stop_s;
    assign n_far       = n_dist_pos ? (n_stop_s < r_dist) : n_dsum[DIST_W-1];
    assign n_cw_side   = n_dist_pos ? r_dir : !r_dir;
    assign n_neg_stop  = -$signed({1'b0, r_stop});
    assign n_neg_ramp  = -r_ramp;

    always_comb begin
        n_ramp_dec = r_ramp;
        if (!n_dist_zero) begin
            if (!r_ramp[31] && (r_ramp != '0)) begin
                if (!n_far || !n_cw_side) n_ramp_dec = n_neg_stop;
            end else if (r_ramp[31]) begin
                if (n_far && n_cw_side) n_ramp_dec = n_neg_ramp;
            end
        end
    end

    // denominator 4n+1 and its magnitude
    assign n_den = $signed({r_ramp, 2'b01});
    assign n_mag = n_den[33] ? 34'(-n_den) : 34'(n_den);

    // apply the recurrence term, saturate, clamp at the shortest interval
    assign n_csum = r_ramp[31] ? ({2'b00, r_interval} + {1'b0, w_rsp.result[32:0]})
                               : ({2'b00, r_interval} - {1'b0, w_rsp.result[32:0]});
    assign n_csat = (|n_csum[33:32]) ? sapu_pkg::INTERVAL_MAX : n_csum[31:0];
    assign n_cnew = (n_csat < r_min_interval) ? r_min_interval : n_csat;

    // integer microseconds of the interval
    assign n_ipart  = r_interval >> FRACTION_BITS;
    assign n_period = (|n_ipart[31:24]) ? sapu_pkg::PERIOD_MAX : n_ipart[23:0];

    assign n_quot    = w_rsp.result[sapu_pkg::OPA_W-1:0];
    assign n_pos_ext = {{32{r_position[PB-1]}}, r_position};

    // sequencer for one item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_position    <= '0;
            r_goal        <= '0;
            r_ramp        <= '0;
            r_interval    <= '0;
            r_step_period <= '0;
            r_dir         <= 1'b0;
            r_in_motion   <= 1'b0;
            r_ticks       <= '0;
            r_cmd.start   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cmd.start <= 1'b0;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_stepped <= 1'b0;
                        r_state   <= S_OUT;
                        if (i_kind) begin
                            if (n_target != r_goal) begin
                                r_goal  <= n_target;
                                r_state <= S_DIST;
                            end
                        end else if (r_step_period != '0) begin
                            if (n_ticks >= {8'd0, r_step_period}) begin
                                r_position <= r_dir ? r_position + PB'(1)
                                                    : r_position - PB'(1);
                                r_ticks    <= '0;
                                r_stepped  <= 1'b1;
                                r_state    <= S_DIST;
                            end else begin
                                r_ticks <= n_ticks;
                            end
                        end
                    end
                end
                S_DIST: begin
                    r_dist <= n_dist;
                    if (r_in_motion) begin
                        r_cmd.start <= 1'b1;
                        r_cmd.op    <= sapu_pkg::OP_MUL;
                        r_cmd.opa   <= {28'd0, r_interval};
                        r_cmd.opb   <= {32'd0, r_interval};
                        r_state     <= S_MUL;
                    end else begin
                        r_stop  <= '0;
                        r_state <= S_DECIDE;
                    end
                end
                S_MUL: begin
                    if (w_rsp.done) begin
                        if (w_rsp.result == '0) begin
                            r_stop  <= sapu_pkg::STOP_MAX;
                            r_state <= S_DECIDE;
                        end else begin
                            r_cmd.start <= 1'b1;
                            r_cmd.op    <= sapu_pkg::OP_DIV;
                            r_cmd.opa   <= r_stop_numerator;
                            r_cmd.opb   <= w_rsp.result;
                            r_state     <= S_DIVS;
                        end
                    end
                end
                S_DIVS: begin
                    if (w_rsp.done) begin
                        r_stop  <= (|n_quot[sapu_pkg::OPA_W-1:sapu_pkg::STOP_W])
                                 ? sapu_pkg::STOP_MAX : n_quot[sapu_pkg::STOP_W-1:0];
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (n_dist_zero && (r_stop <= 31'd1)) begin
                        // target reached at rest speed: stop
                        r_step_period <= '0;
                        r_in_motion   <= 1'b0;
                        r_ramp        <= '0;
                        r_state       <= S_OUT;
                    end else begin
                        r_ramp  <= n_ramp_dec;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_ramp == '0) begin
                        r_interval <= r_first_interval;
                        r_dir      <= n_dist_pos;
                        r_state    <= S_FIN;
                    end else begin
                        r_cmd.start <= 1'b1;
                        r_cmd.op    <= sapu_pkg::OP_DIV;
                        r_cmd.opa   <= {27'd0, r_interval, 1'b0};
                        r_cmd.opb   <= {30'd0, n_mag};
                        r_state     <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (w_rsp.done) begin
                        r_interval <= n_cnew;
                        r_state    <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_ramp        <= (r_ramp == $signed(sapu_pkg::RAMP_MAX))
                                   ? r_ramp : r_ramp + 32'sd1;
                    r_step_period <= n_period;
                    r_in_motion   <= 1'b1;
                    r_state       <= S_OUT;
                end
                S_OUT: begin
                    // hand the word over once the output register frees
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_stepped  <= r_stepped;
                        r_out_coil     <= 4'b1000 >> r_position[1:0];
                        r_out_position <= n_pos_ext[31:0];
                        r_out_dir      <= r_dir;
                        r_out_busy     <= r_in_motion || (r_goal != r_position);
                        r_out_interval <= r_step_period;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_stepped          = r_out_stepped;
    assign o_coil_pattern     = r_out_coil;
    assign o_position         = $signed(r_out_position);
    assign o_moving_clockwise = r_out_dir;
    assign o_busy_res         = r_out_busy;
    assign o_interval_us      = r_out_interval;

    `SAPU_ASSERT_IMPL(a_rest_state, i_clk, i_rst_n, !r_in_motion, (r_ramp == '0) && (r_step_period == '0), "ramp state left at rest")
    `SAPU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE, "item accepted but not processed")
    `SAPU_ASSERT_IMPL(a_word_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_OUT), "output word outside hand-over")

endmodule
`default_nettype wire

[dv/tb.sv]
module tb;

    localparam int     POS_BITS     = 32;
    localparam int     FRAC_BITS    = 8;
    localparam int     RANDOM_ITEMS = 1750;
    localparam int     TAIL_ITEMS   = 150;
    localparam int     CYCLE_LIMIT  = 1500000;
    localparam int     DRAIN_CYCLES = 200;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     HOLD_AFTER   = 150;
    localparam int     REPORT_CAP   = 40;
    localparam longint STOP_CAP     = longint'(sapu_pkg::STOP_MAX);
    localparam longint RAMP_CAP     = longint'(sapu_pkg::RAMP_MAX);

    typedef struct packed {
        logic          stepped;
        logic [3:0]    coil;
        logic [31:0]   position;
        logic          cw;
        logic          busy;
        logic [23:0]   interval;
    } t_step_word;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_TARGET,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind     what;
        logic [1:0]    index;
        logic [59:0]   value;
        logic          typed;
        t_step_word    want;
    } t_stim_row;

    localparam t_step_word WORD_AT_REST = '{1'b0, 4'd8, 32'd0, 1'b0, 1'b0, 24'd0};
    localparam t_step_word WORD_SLOWEST = '{1'b0, 4'd8, 32'd0, 1'b1, 1'b1,
                                            sapu_pkg::PERIOD_MAX};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [59:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_kind;
    logic signed [31:0] i_target_position;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_stepped;
    logic [3:0]         o_coil_pattern;
    logic signed [31:0] o_position;
    logic               o_moving_clockwise;
    logic               o_busy_res;
    logic [23:0]        o_interval_us;

    stepper_accel_profile_unit #(
        .POSITION_BITS(POS_BITS),
        .FRACTION_BITS(FRAC_BITS)
    ) DUT (.*);

    // ramp model: settings and motion state
    logic [31:0] c0_cfg;
    logic [31:0] cmin_cfg;
    logic [59:0] stopnum_cfg;
    logic [31:0] pos_q;
    logic [31:0] goal_q;
    logic [31:0] elapsed_q;
    longint      ramp_n;
    logic [63:0] ivl_fx;
    logic [23:0] period_q;
    logic        cw_q;
    logic        moving_q;

    t_step_word  pending_words[$];
    int          words_checked;
    int          mismatches;
    int          steps_seen;
    int          targets_loaded;
    int          reg_writes;
    int          items_sent;
    int          cycle_count;
    bit          tail_quiet;
    bit          sender_noisy;
    bit          pressure_done;

    // directed script: typed words only where they follow at a glance
    t_stim_row script [26] = '{
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b1, WORD_AT_REST},
        '{ROW_TARGET, sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b1, WORD_AT_REST},
        '{ROW_CFG,    sapu_pkg::CFG_FIRST_INTERVAL, 60'hFFFF_FFFF,          1'b0, WORD_AT_REST},
        '{ROW_TARGET, sapu_pkg::CFG_FIRST_INTERVAL, 60'd3,                  1'b1, WORD_SLOWEST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_CFG,    sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_TARGET, sapu_pkg::CFG_FIRST_INTERVAL, 60'h8000_0000,          1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_TARGET, sapu_pkg::CFG_FIRST_INTERVAL, 60'h7FFF_FFFF,          1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_CFG,    sapu_pkg::CFG_STOP_NUMERATOR, 60'd1,                  1'b0, WORD_AT_REST},
        '{ROW_TARGET, sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_CFG,    sapu_pkg::CFG_MIN_INTERVAL,   60'd1,                  1'b0, WORD_AT_REST},
        '{ROW_CFG,    sapu_pkg::CFG_FIRST_INTERVAL, 60'd512,                1'b0, WORD_AT_REST},
        '{ROW_CFG,    sapu_pkg::CFG_STOP_NUMERATOR, 60'hFFF_FFFF_FFFF_FFFF, 1'b0, WORD_AT_REST},
        '{ROW_TARGET, sapu_pkg::CFG_FIRST_INTERVAL, 60'd4,                  1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_TARGET, sapu_pkg::CFG_FIRST_INTERVAL, 60'hFFFF_FFF9,          1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST},
        '{ROW_CFG,    sapu_pkg::CFG_MIN_INTERVAL,   60'hFFFF_FFFF,          1'b0, WORD_AT_REST},
        '{ROW_TICK,   sapu_pkg::CFG_FIRST_INTERVAL, 60'd0,                  1'b0, WORD_AT_REST}
    };

    // clock: period 4
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic longint travel_left();
        return longint'($signed(goal_q)) - longint'($signed(pos_q));
    endfunction

    // recompute interval, ramp index and direction after a step or a new goal
    function automatic void update_ramp();
        longint      gap;
        longint      stop;
        longint      n;
        longint      d;
        logic [63:0] sq;
        logic [63:0] q;
        logic [63:0] mag;
        logic [63:0] delta;
        logic [63:0] c;
        gap  = travel_left();
        stop = 0;
        n    = ramp_n;
        if (moving_q) begin
            sq = ivl_fx * ivl_fx;
            if (sq == 64'd0) begin
                stop = STOP_CAP;
            end else begin
                q    = {4'h0, stopnum_cfg} / sq;
                stop = (q > 64'(STOP_CAP)) ? STOP_CAP : longint'(q);
            end
        end
        // at the goal and able to stop: drop to rest
        if (gap == 0 && stop <= 1) begin
            period_q = '0;
            moving_q = 1'b0;
            ramp_n   = 0;
            return;
        end
        // pick acceleration or deceleration
        if (gap > 0) begin
            if (n > 0) begin
                if (stop >= gap || !cw_q) n = -stop;
            end else if (n < 0) begin
                if (stop < gap && cw_q) n = -n;
            end
        end else if (gap < 0) begin
            if (n > 0) begin
                if (stop >= -gap || cw_q) n = -stop;
            end else if (n < 0) begin
                if (stop < -gap && !cw_q) n = -n;
            end
        end
        if (n == 0) begin
            ivl_fx = 64'(c0_cfg);
            cw_q   = gap > 0;
        end else begin
            d     = 4 * n + 1;
            mag   = (d < 0) ? -d : d;
            delta = (ivl_fx << 1) / mag;
            c     = (d > 0) ? ivl_fx - delta : ivl_fx + delta;
            if (c > 64'(sapu_pkg::INTERVAL_MAX)) c = 64'(sapu_pkg::INTERVAL_MAX);
            if (c < 64'(cmin_cfg)) c = 64'(cmin_cfg);
            ivl_fx = c;
        end
        n++;
        if (n > RAMP_CAP) n = RAMP_CAP;
        ramp_n   = n;
        q        = ivl_fx >> FRAC_BITS;
        period_q = (q > 64'(sapu_pkg::PERIOD_MAX)) ? sapu_pkg::PERIOD_MAX : q[23:0];
        moving_q = 1'b1;
    endfunction

    // advance the model by one item and form the word it returns
    function automatic t_step_word predict_word(input logic kind, input logic [31:0] tgt);
        t_step_word w;
        w.stepped = 1'b0;
        if (kind) begin
            if (tgt != goal_q) begin
                goal_q = tgt;
                update_ramp();
            end
        end else if (period_q != '0) begin
            if (elapsed_q != '1) elapsed_q++;
            if (elapsed_q >= 32'(period_q)) begin
                pos_q     = cw_q ? pos_q + 32'd1 : pos_q - 32'd1;
                elapsed_q = '0;
                w.stepped = 1'b1;
                update_ramp();
            end
        end
        w.coil     = 4'd8 >> pos_q[1:0];
        w.position = pos_q;
        w.cw       = cw_q;
        w.busy     = moving_q || (travel_left() != 0);
        w.interval = period_q;
        return w;
    endfunction

    // hold valid until the word is taken, then log its expected result
    task automatic offer_word(input logic kind, input logic [31:0] tgt,
                              input logic typed = 1'b0, input t_step_word want = '0);
        t_step_word modelled;
        i_in_valid        <= 1'b1;
        i_kind            <= kind;
        i_target_position <= tgt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (kind && tgt != goal_q) targets_loaded++;
        modelled = predict_word(kind, tgt);
        if (modelled.stepped) steps_seen++;
        pending_words.push_back(typed ? want : modelled);
        if (sender_noisy && !tail_quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // registers load only with nothing in flight
    task automatic write_reg(input logic [1:0] idx, input logic [59:0] val);
        drain_words();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            sapu_pkg::CFG_FIRST_INTERVAL: c0_cfg = val[31:0];
            sapu_pkg::CFG_MIN_INTERVAL:   cmin_cfg = val[31:0];
            default:                      stopnum_cfg = val;
        endcase
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch on word %0d: expected 0x%0h, actual 0x%0h",
                         $time, label, words_checked, want, got);
        end
    endtask

    // receiver: check each word taken, then choose ready for the next cycle
    initial begin
        t_step_word want;
        int         hold_left;
        int         stall_left;
        int         cyc;
        bit         noisy;
        hold_left  = 0;
        stall_left = 0;
        cyc        = 0;
        noisy      = 1'b1;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (pending_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: result word with nothing expected, position 0x%0h",
                                 $time, o_position);
                end else begin
                    want = pending_words.pop_front();
                    compare_field("stepped", 32'(want.stepped), 32'(o_stepped));
                    compare_field("coil_pattern", 32'(want.coil), 32'(o_coil_pattern));
                    compare_field("position", want.position, o_position);
                    compare_field("moving_clockwise", 32'(want.cw), 32'(o_moving_clockwise));
                    compare_field("busy_res", 32'(want.busy), 32'(o_busy_res));
                    compare_field("interval_us", 32'(want.interval), 32'(o_interval_us));
                end
                words_checked++;
            end
            cyc++;
            if (cyc % 256 == 0) noisy = $urandom_range(0, 2) != 0;
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!pressure_done && words_checked >= HOLD_AFTER && i_in_valid) begin
                // long hold-off while items keep coming: let the block back up
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (noisy && !tail_quiet && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: cycle limit hit, %0d words still awaited", $time, pending_words.size());
        $display("stepper_accel_profile_unit verification failed");
        $finish;
    end

    // stimulus
    initial begin
        int          phase_len;
        int          r;
        int          k;
        int          tries;
        logic [31:0] c0;
        logic [31:0] cmin;
        logic [63:0] sn;
        bit          park;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= sapu_pkg::CFG_FIRST_INTERVAL;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_kind            <= 1'b0;
        i_target_position <= '0;

        c0_cfg      = sapu_pkg::FIRST_INTERVAL_RST;
        cmin_cfg    = sapu_pkg::MIN_INTERVAL_RST;
        stopnum_cfg = sapu_pkg::STOP_NUMERATOR_RST;
        pos_q       = '0;
        goal_q      = '0;
        elapsed_q   = '0;
        ramp_n      = 0;
        ivl_fx      = '0;
        period_q    = '0;
        cw_q        = 1'b0;
        moving_q    = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed script
        sender_noisy = 1'b1;
        foreach (script[i]) begin
            case (script[i].what)
                ROW_CFG:  write_reg(script[i].index, script[i].value);
                ROW_TICK: offer_word(1'b0, $urandom(), script[i].typed, script[i].want);
                default:  offer_word(1'b1, script[i].value[31:0], script[i].typed,
                                     script[i].want);
            endcase
        end

        // random phases, each with its own ramp settings
        while (items_sent < RANDOM_ITEMS) begin
            sender_noisy = $urandom_range(0, 2) != 0;
            park         = $urandom_range(0, 3) != 0;
            c0           = $urandom_range(2 * 256, 12 * 256);
            cmin         = $urandom_range(256, c0);
            sn           = 64'(c0) * 64'(c0) * $urandom_range(1, 20);
            case ($urandom_range(0, 11))
                0: c0 = sapu_pkg::INTERVAL_MAX;
                1: c0 = $urandom_range(0, 255);
                2: cmin = 32'd1;
                3: begin
                    // ramp runs down below a microsecond and stalls
                    cmin = $urandom_range(1, 255);
                    c0   = $urandom_range(256, 600);
                end
                4: sn = 64'd1;
                5: sn = {4'h0, 60'hFFF_FFFF_FFFF_FFFF};
                default: ;
            endcase
            if (park) begin
                // bring the motor to rest at its position first
                write_reg(sapu_pkg::CFG_STOP_NUMERATOR, 60'd1);
                tries = 0;
                while ((moving_q || goal_q != pos_q) && tries < 4) begin
                    if (goal_q == pos_q) offer_word(1'b1, pos_q + 32'd1);
                    offer_word(1'b1, pos_q);
                    tries++;
                end
                write_reg(sapu_pkg::CFG_FIRST_INTERVAL, 60'(c0));
                write_reg(sapu_pkg::CFG_MIN_INTERVAL, 60'(cmin));
                write_reg(sapu_pkg::CFG_STOP_NUMERATOR, sn[59:0]);
            end else begin
                // reload part of the settings while the motor may still run
                if ($urandom_range(0, 1)) write_reg(sapu_pkg::CFG_FIRST_INTERVAL, 60'(c0));
                if ($urandom_range(0, 1)) write_reg(sapu_pkg::CFG_MIN_INTERVAL, 60'(cmin));
                write_reg(sapu_pkg::CFG_STOP_NUMERATOR, sn[59:0]);
            end
            phase_len = $urandom_range(80, 200);
            for (k = 0; k < phase_len && items_sent < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    offer_word(1'b0, $urandom());
                else if (r < 94)
                    offer_word(1'b1, pos_q + $urandom_range(0, 60) - 32'd30);
                else if (r < 98)
                    offer_word(1'b1, $urandom());
                else
                    offer_word(1'b1, goal_q);
                if (items_sent >= RANDOM_ITEMS - TAIL_ITEMS) tail_quiet = 1'b1;
            end
        end

        // wait out the last words, then run on for DRAIN_CYCLES more
        drain_words();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items and %0d result words: %0d steps, %0d target loads, %0d register writes",
                 items_sent, words_checked, steps_seen, targets_loaded, reg_writes);
        $display("Mismatches %0d, words still awaited %0d", mismatches, pending_words.size());
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("stepper_accel_profile_unit verification clean");
        end else begin
            $display("stepper_accel_profile_unit verification failed");
        end
        $finish;
    end

endmodule

[stepper_accel_profile_unit.f]
+incdir+design
design/sapu_pkg.sv
design/sapu_serial.sv
design/stepper_accel_profile_unit.sv
dv/tb.sv
